// ===== sv/rccp_pkg.sv =====
`timescale 1ns / 1ps
package rccp_pkg;

   localparam int unsigned QueueDepth = 4;

   // result kinds
   localparam logic [1:0] KIND_GROUP  = 2'd0;
   localparam logic [1:0] KIND_FINISH = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // error codes
   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_OP_FIRST    = 4'd1;
   localparam logic [3:0] ERR_RAW_CTRL    = 4'd2;
   localparam logic [3:0] ERR_OP_SEQ      = 4'd3;
   localparam logic [3:0] ERR_CARET_END   = 4'd4;
   localparam logic [3:0] ERR_STRAY_CLOSE = 4'd5;
   localparam logic [3:0] ERR_DANGLE_ESC  = 4'd6;
   localparam logic [3:0] ERR_UNCLOSED    = 4'd7;
   localparam logic [3:0] ERR_EMPTY_CLS   = 4'd8;
   localparam logic [3:0] ERR_LEAD_DASH   = 4'd9;
   localparam logic [3:0] ERR_DASH_CLOSE  = 4'd10;
   localparam logic [3:0] ERR_REVERSED    = 4'd11;
   localparam logic [3:0] ERR_CHAINED     = 4'd12;
   localparam logic [3:0] ERR_SPECIAL     = 4'd13;

   // byte constants
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CARET = 8'h5e;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_RBRK  = 8'h5d;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_QUES  = 8'h3f;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_T     = 8'h74;

   // previous byte kinds
   localparam logic [1:0] PREV_NORMAL = 2'd0;
   localparam logic [1:0] PREV_OP     = 2'd1;
   localparam logic [1:0] PREV_CARET  = 2'd2;

   // operation handed from front to back
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_SET    = 3'd1,
      OP_ALL    = 3'd2,
      OP_RANGE  = 3'd3,
      OP_EMIT   = 3'd4,
      OP_FINISH = 3'd5,
      OP_REJECT = 3'd6
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       neg_set;   // set negate flag
      logic       clr_after; // clear group set and negate flag after this op
      logic [7:0] lo;
      logic [7:0] hi;
      logic [1:0] rep;
      logic [3:0] err;
      logic       chain;     // a second op follows from same byte
   } cmd_type;

   typedef struct packed {
      logic [255:0] set_bits;
      logic         negated;
      logic [1:0]   repeat_kind;
      logic [1:0]   result_kind;
      logic [3:0]   error_code;
      logic         last_of_run;
   } rsp_type;

   function automatic logic is_op(input logic [7:0] b);
      return (b == CH_STAR) || (b == CH_PLUS) || (b == CH_QUES);
   endfunction

   function automatic logic [1:0] op_code(input logic [7:0] b);
      return (b == CH_STAR) ? 2'd1 : ((b == CH_PLUS) ? 2'd2 : 2'd3);
   endfunction

   function automatic logic cls_special(input logic [7:0] b);
      return is_op(b) || (b == CH_CARET) || (b == CH_LBRK) || (b == CH_DOT);
   endfunction

   function automatic logic [7:0] esc_value(input logic [7:0] b);
      return (b == CH_N) ? CH_LF : ((b == CH_T) ? CH_TAB : b);
   endfunction

endpackage

// ===== sv/rccp_req_if.sv =====
`timescale 1ns / 1ps
interface rccp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pattern_char;
   modport source (output valid, output pattern_char, input ready);
   modport sink (input valid, input pattern_char, output ready);
endinterface

// ===== sv/rccp_rsp_if.sv =====
`timescale 1ns / 1ps
interface rccp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] set_bits_0;
   logic [63:0] set_bits_1;
   logic [63:0] set_bits_2;
   logic [63:0] set_bits_3;
   logic        negated;
   logic [1:0]  repeat_kind;
   logic [1:0]  result_kind;
   logic [3:0]  error_code;
   logic        last_of_run;
   modport source (output valid, output set_bits_0, output set_bits_1,
                   output set_bits_2, output set_bits_3, output negated,
                   output repeat_kind, output result_kind, output error_code,
                   output last_of_run, input ready);
   modport sink (input valid, input set_bits_0, input set_bits_1,
                 input set_bits_2, input set_bits_3, input negated,
                 input repeat_kind, input result_kind, input error_code,
                 input last_of_run, output ready);
endinterface

// ===== sv/rccp_front.sv =====
`timescale 1ns / 1ps
module rccp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_char,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output rccp_pkg::cmd_type   cmd_a,
   output rccp_pkg::cmd_type   cmd_b
);

   typedef enum logic [9:0] {
      PH_START     = 10'b0000000001,
      PH_ESC       = 10'b0000000010,
      PH_AFTER     = 10'b0000000100,
      PH_CLS_FIRST = 10'b0000001000,
      PH_CLS_BODY  = 10'b0000010000,
      PH_CLS_ESC   = 10'b0000100000,
      PH_CLS_HELD  = 10'b0001000000,
      PH_CLS_DASH  = 10'b0010000000,
      PH_CLS_RANGED= 10'b0100000000,
      PH_DRAIN     = 10'b1000000000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] prev_ff, prev_in;
   logic       seen_ff, seen_in;
   rccp_pkg::cmd_type ca, cb;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid;
   assign cmd_a     = ca;
   assign cmd_b     = cb;

   function automatic rccp_pkg::cmd_type mk(input rccp_pkg::op_type op);
      rccp_pkg::cmd_type c;
      c = '0;
      c.op = op;
      return c;
   endfunction

   // byte classification and phase decisions
   always_comb begin
      logic [7:0] b;
      logic       start;  // run start-of-group handling on b
      logic       body;   // run class body handling on b
      rccp_pkg::cmd_type s;
      b        = in_char;
      phase_in = phase_ff;
      held_in  = held_ff;
      prev_in  = prev_ff;
      seen_in  = seen_ff;
      ca       = mk(rccp_pkg::OP_NONE);
      cb       = mk(rccp_pkg::OP_NONE);
      start    = 1'b0;
      body     = 1'b0;
      s        = mk(rccp_pkg::OP_NONE);
      case (phase_ff)
         PH_START: start = 1'b1;
         PH_ESC: begin
            if (b == rccp_pkg::CH_NUL) begin
               s = mk(rccp_pkg::OP_REJECT); s.err = rccp_pkg::ERR_DANGLE_ESC;
            end else begin
               s = mk(rccp_pkg::OP_SET); s.lo = rccp_pkg::esc_value(b);
               phase_in = PH_AFTER;
            end
            ca = s;
         end
         PH_AFTER: begin
            ca = mk(rccp_pkg::OP_EMIT);
            ca.clr_after = 1'b1;
            if (rccp_pkg::is_op(b)) begin
               ca.rep   = rccp_pkg::op_code(b);
               prev_in  = rccp_pkg::PREV_OP;
               phase_in = PH_START;
            end else begin
               prev_in  = rccp_pkg::PREV_NORMAL;
               phase_in = PH_START;
               start    = 1'b1;
            end
         end
         PH_CLS_FIRST: begin
            if (b == rccp_pkg::CH_NUL) begin
               ca = mk(rccp_pkg::OP_REJECT); ca.err = rccp_pkg::ERR_UNCLOSED;
            end else if (b == rccp_pkg::CH_RBRK) begin
               ca = mk(rccp_pkg::OP_REJECT); ca.err = rccp_pkg::ERR_EMPTY_CLS;
            end else if (b == rccp_pkg::CH_DASH) begin
               ca = mk(rccp_pkg::OP_REJECT); ca.err = rccp_pkg::ERR_LEAD_DASH;
            end else body = 1'b1;
         end
         PH_CLS_BODY: body = 1'b1;
         PH_CLS_ESC: begin
            if (b == rccp_pkg::CH_NUL) begin
               ca = mk(rccp_pkg::OP_REJECT); ca.err = rccp_pkg::ERR_DANGLE_ESC;
            end else begin
               ca = mk(rccp_pkg::OP_SET); ca.lo = rccp_pkg::esc_value(b);
               phase_in = PH_CLS_BODY;
            end
         end
         PH_CLS_HELD: begin
            if (b == rccp_pkg::CH_DASH) phase_in = PH_CLS_DASH;
            else if (rccp_pkg::cls_special(held_ff)) begin
               ca = mk(rccp_pkg::OP_REJECT); ca.err = rccp_pkg::ERR_SPECIAL;
            end else begin
               ca = mk(rccp_pkg::OP_SET); ca.lo = held_ff;
               phase_in = PH_CLS_BODY;
               body = 1'b1;
            end
         end
         PH_CLS_DASH: begin
            if (b == rccp_pkg::CH_NUL) begin
               ca = mk(rccp_pkg::OP_REJECT);
               ca.err = rccp_pkg::cls_special(held_ff) ? rccp_pkg::ERR_SPECIAL
                                                       : rccp_pkg::ERR_UNCLOSED;
            end else if (b == rccp_pkg::CH_RBRK) begin
               ca = mk(rccp_pkg::OP_REJECT); ca.err = rccp_pkg::ERR_DASH_CLOSE;
            end else if (held_ff > b) begin
               ca = mk(rccp_pkg::OP_REJECT); ca.err = rccp_pkg::ERR_REVERSED;
            end else begin
               ca = mk(rccp_pkg::OP_RANGE); ca.lo = held_ff; ca.hi = b;
               phase_in = PH_CLS_RANGED;
            end
         end
         PH_CLS_RANGED: begin
            if (b == rccp_pkg::CH_DASH) begin
               ca = mk(rccp_pkg::OP_REJECT); ca.err = rccp_pkg::ERR_CHAINED;
            end else begin
               phase_in = PH_CLS_BODY;
               body = 1'b1;
            end
         end
         PH_DRAIN: begin
            if (b == rccp_pkg::CH_NUL) begin
               phase_in = PH_START; held_in = '0;
               prev_in = rccp_pkg::PREV_NORMAL; seen_in = 1'b0;
               ca = mk(rccp_pkg::OP_FINISH); ca.clr_after = 1'b1; // silent clear
               ca.op = rccp_pkg::OP_NONE;
            end
         end
         default: phase_in = PH_START;
      endcase

      // class body step (result goes in the free slot)
      if (body) begin
         s = mk(rccp_pkg::OP_NONE);
         if (b == rccp_pkg::CH_RBRK) phase_in = PH_AFTER;
         else if (b == rccp_pkg::CH_NUL) begin
            s = mk(rccp_pkg::OP_REJECT); s.err = rccp_pkg::ERR_UNCLOSED;
         end else if (b == rccp_pkg::CH_LF || b == rccp_pkg::CH_TAB) begin
            s = mk(rccp_pkg::OP_REJECT); s.err = rccp_pkg::ERR_RAW_CTRL;
         end else if (b == rccp_pkg::CH_BSL) phase_in = PH_CLS_ESC;
         else begin
            held_in = b; phase_in = PH_CLS_HELD;
         end
         if (ca.op == rccp_pkg::OP_NONE) ca = s;
         else cb = s;
      end

      // start of group step
      if (start) begin
         s = mk(rccp_pkg::OP_NONE);
         if (prev_ff == rccp_pkg::PREV_CARET && phase_ff == PH_START) begin
            if (b == rccp_pkg::CH_NUL) begin
               s = mk(rccp_pkg::OP_REJECT); s.err = rccp_pkg::ERR_CARET_END;
            end else if (b == rccp_pkg::CH_CARET || rccp_pkg::is_op(b)) begin
               s = mk(rccp_pkg::OP_REJECT); s.err = rccp_pkg::ERR_OP_SEQ;
            end else begin
               prev_in = rccp_pkg::PREV_NORMAL;
               if (b == rccp_pkg::CH_BSL) phase_in = PH_ESC;
               else if (b == rccp_pkg::CH_DOT) begin
                  s = mk(rccp_pkg::OP_ALL); phase_in = PH_AFTER;
               end else if (b == rccp_pkg::CH_LBRK) phase_in = PH_CLS_FIRST;
               else if (b == rccp_pkg::CH_RBRK) begin
                  s = mk(rccp_pkg::OP_REJECT); s.err = rccp_pkg::ERR_STRAY_CLOSE;
               end else begin
                  s = mk(rccp_pkg::OP_SET); s.lo = b; phase_in = PH_AFTER;
               end
            end
         end else if (b == rccp_pkg::CH_NUL) begin
            s = mk(rccp_pkg::OP_FINISH);
            phase_in = PH_START; held_in = '0;
            prev_in = rccp_pkg::PREV_NORMAL; seen_in = 1'b0;
         end else if (rccp_pkg::is_op(b)) begin
            s = mk(rccp_pkg::OP_REJECT);
            s.err = (seen_ff && phase_ff == PH_START) ? rccp_pkg::ERR_OP_SEQ
                  : (phase_ff == PH_AFTER ? rccp_pkg::ERR_OP_SEQ
                                          : rccp_pkg::ERR_OP_FIRST);
         end else if (b == rccp_pkg::CH_LF || b == rccp_pkg::CH_TAB) begin
            s = mk(rccp_pkg::OP_REJECT); s.err = rccp_pkg::ERR_RAW_CTRL;
         end else begin
            seen_in = 1'b1;
            if (b == rccp_pkg::CH_CARET) begin
               s = mk(rccp_pkg::OP_NONE); s.neg_set = 1'b1;
               prev_in = rccp_pkg::PREV_CARET;
               phase_in = PH_START;
            end else begin
               prev_in = rccp_pkg::PREV_NORMAL;
               if (b == rccp_pkg::CH_BSL) phase_in = PH_ESC;
               else if (b == rccp_pkg::CH_DOT) begin
                  s = mk(rccp_pkg::OP_ALL); phase_in = PH_AFTER;
               end else if (b == rccp_pkg::CH_LBRK) phase_in = PH_CLS_FIRST;
               else if (b == rccp_pkg::CH_RBRK) begin
                  s = mk(rccp_pkg::OP_REJECT); s.err = rccp_pkg::ERR_STRAY_CLOSE;
               end else begin
                  s = mk(rccp_pkg::OP_SET); s.lo = b; phase_in = PH_AFTER;
               end
            end
         end
         if (ca.op == rccp_pkg::OP_NONE && !ca.clr_after) ca = s;
         else cb = s;
      end

      // rejection: drain or restart, and terminator clears the pattern
      if (ca.op == rccp_pkg::OP_REJECT || cb.op == rccp_pkg::OP_REJECT) begin
         if (b == rccp_pkg::CH_NUL) begin
            phase_in = PH_START; held_in = '0;
            prev_in = rccp_pkg::PREV_NORMAL; seen_in = 1'b0;
         end else phase_in = PH_DRAIN;
      end
      // whole-pattern clear on finish and reject (a terminator in drain sets its own clear above)
      if (ca.op == rccp_pkg::OP_REJECT || cb.op == rccp_pkg::OP_REJECT ||
          ca.op == rccp_pkg::OP_FINISH || cb.op == rccp_pkg::OP_FINISH) begin
         if (ca.op == rccp_pkg::OP_REJECT || ca.op == rccp_pkg::OP_FINISH)
            ca.clr_after = 1'b1;
         else cb.clr_after = 1'b1;
      end
      ca.chain = (cb.op != rccp_pkg::OP_NONE) || cb.neg_set || cb.clr_after;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         held_ff  <= '0;
         prev_ff  <= rccp_pkg::PREV_NORMAL;
         seen_ff  <= 1'b0;
      end else if (in_valid && in_ready) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         prev_ff  <= prev_in;
         seen_ff  <= seen_in;
      end
   end

   property p_drain_stays;
      @(posedge clock) disable iff (reset)
      (phase_ff == PH_DRAIN && in_valid && in_ready && in_char != rccp_pkg::CH_NUL)
         |=> (phase_ff == PH_DRAIN);
   endproperty
   a_drain_stays: assert property (p_drain_stays) else $error("drain left early");

   property p_drain_quiet;
      @(posedge clock) disable iff (reset)
      (phase_ff == PH_DRAIN) |-> (ca.op == rccp_pkg::OP_NONE);
   endproperty
   a_drain_quiet: assert property (p_drain_quiet) else $error("result in drain");

   property p_single_reject;
      @(posedge clock) disable iff (reset)
      !(ca.op == rccp_pkg::OP_REJECT && cb.op == rccp_pkg::OP_REJECT);
   endproperty
   a_single_reject: assert property (p_single_reject) else $error("two rejects");

endmodule

// ===== sv/rccp_back.sv =====
`timescale 1ns / 1ps
module rccp_back #(
   parameter int unsigned QUEUE_DEPTH = rccp_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  rccp_pkg::cmd_type cmd_a,
   input  rccp_pkg::cmd_type cmd_b,
   output logic              out_valid,
   input  logic              out_ready,
   output rccp_pkg::rsp_type out_data
);

   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // command queue, each entry is one (possibly paired) command word
   rccp_pkg::cmd_type qa_mem [QUEUE_DEPTH];
   rccp_pkg::cmd_type qb_mem [QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          push, pop;
   rccp_pkg::cmd_type ha, hb;
   logic          half_ff; // first half of a paired entry already done

   // group accumulator
   logic [255:0] set_ff, set_in;
   logic         neg_ff, neg_in;
   rccp_pkg::cmd_type cur;
   logic         cur_last, cur_emits;
   rccp_pkg::rsp_type rsp;
   logic         step;

   assign cmd_ready = (cnt_ff != QUEUE_DEPTH[AW:0]);
   assign push      = cmd_valid && cmd_ready;
   assign ha        = qa_mem[rp_ff];
   assign hb        = qb_mem[rp_ff];
   assign cur       = half_ff ? hb : ha;
   assign cur_last  = half_ff || !ha.chain;
   assign cur_emits = (cur.op == rccp_pkg::OP_EMIT) || (cur.op == rccp_pkg::OP_FINISH) ||
                      (cur.op == rccp_pkg::OP_REJECT);

   // output register, taken when empty or drained
   logic out_free;
   assign out_free = !out_valid || out_ready;
   assign step     = (cnt_ff != '0) && (!cur_emits || out_free);
   assign pop      = step && cur_last;

   // range mask and response build
   always_comb begin
      logic [255:0] rmask;
      for (int i = 0; i < 256; i++)
         rmask[i] = (i[7:0] >= cur.lo) && (i[7:0] <= cur.hi);
      set_in = set_ff;
      neg_in = neg_ff;
      rsp    = '0;
      rsp.last_of_run = cur_last || !(hb.op == rccp_pkg::OP_EMIT ||
                        hb.op == rccp_pkg::OP_FINISH || hb.op == rccp_pkg::OP_REJECT);
      case (cur.op)
         rccp_pkg::OP_SET:   set_in = set_ff | (256'd1 << cur.lo);
         rccp_pkg::OP_ALL:   set_in = '1;
         rccp_pkg::OP_RANGE: set_in = set_ff | rmask;
         rccp_pkg::OP_EMIT: begin
            rsp.set_bits    = set_ff;
            rsp.negated     = neg_ff;
            rsp.repeat_kind = cur.rep;
            rsp.result_kind = rccp_pkg::KIND_GROUP;
         end
         rccp_pkg::OP_FINISH: rsp.result_kind = rccp_pkg::KIND_FINISH;
         rccp_pkg::OP_REJECT: begin
            rsp.result_kind = rccp_pkg::KIND_REJECT;
            rsp.error_code  = cur.err;
         end
         default: ;
      endcase
      if (cur.neg_set) neg_in = 1'b1;
      if (cur.clr_after) begin
         set_in = '0;
         neg_in = 1'b0;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         qa_mem[wp_ff] <= cmd_a;
         qb_mem[wp_ff] <= cmd_b;
      end
   end

   // queue pointers and execution state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
         half_ff <= 1'b0;
         set_ff  <= '0;
         neg_ff  <= 1'b0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
         if (step) begin
            half_ff <= !cur_last;
            set_ff  <= set_in;
            neg_ff  <= neg_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (out_free) out_valid <= step && cur_emits;
   end
   always_ff @(posedge clock) begin
      if (out_free && step && cur_emits) out_data <= rsp;
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) cnt_ff <= QUEUE_DEPTH[AW:0];
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

   property p_hold;
      @(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_data));
   endproperty
   a_hold: assert property (p_hold) else $error("result lost");

   property p_empty_idle;
      @(posedge clock) disable iff (reset) (cnt_ff == '0) |-> !step;
   endproperty
   a_empty_idle: assert property (p_empty_idle) else $error("step on empty queue");

endmodule

// ===== sv/regex_char_class_parser.sv =====
`timescale 1ns / 1ps
// with an empty queue a byte's first result passes the command queue and then the result register;
// a second result from the same byte takes a further back-end step
// throughput: one byte per cycle while each byte needs one back-end step and results are taken;
// a byte that closes a group and also starts one or ends the pattern needs two steps
// a command queue of QUEUE_DEPTH entries (four by default) lets parser and result side stall apart
// reset: synchronous, active high; clears parser phase, queue and group set
module regex_char_class_parser #(
   parameter int unsigned QUEUE_DEPTH = rccp_pkg::QueueDepth
) (
   input logic       clock,
   input logic       reset,
   rccp_req_if.sink  req,
   rccp_rsp_if.source rsp
);

   logic              cmd_valid, cmd_ready;
   rccp_pkg::cmd_type cmd_a, cmd_b;
   rccp_pkg::rsp_type out_data;

   rccp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_char   (req.pattern_char),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_a     (cmd_a),
      .cmd_b     (cmd_b)
   );

   rccp_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_a     (cmd_a),
      .cmd_b     (cmd_b),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_data)
   );

   // result fields
   assign rsp.set_bits_0  = out_data.set_bits[63:0];
   assign rsp.set_bits_1  = out_data.set_bits[127:64];
   assign rsp.set_bits_2  = out_data.set_bits[191:128];
   assign rsp.set_bits_3  = out_data.set_bits[255:192];
   assign rsp.negated     = out_data.negated;
   assign rsp.repeat_kind = out_data.repeat_kind;
   assign rsp.result_kind = out_data.result_kind;
   assign rsp.error_code  = out_data.error_code;
   assign rsp.last_of_run = out_data.last_of_run;

endmodule
